@@ rtl/sandpile_grain_drop_defines.svh @@
// Assertion macros for the sandpile grain drop block.
`ifndef SANDPILE_GRAIN_DROP_DEFINES_SVH
`define SANDPILE_GRAIN_DROP_DEFINES_SVH

// Condition that holds at every clock edge out of reset.
`define SGD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define SGD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SGD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/sgd_pkg.sv @@
// Shared types and constants for the sandpile grain drop block.
`default_nettype none
package sgd_pkg;

  localparam int DEFAULT_GRID_SIDE = 16;
  localparam int TOPPLE_AT         = 4;
  localparam int IN_TDATA_W        = 16;
  localparam int IN_TUSER_W        = 2;
  localparam int OUT_TDATA_W       = 40;
  localparam int SIZE_W            = 32;
  localparam int TOPPLE_W          = 31;

  localparam logic [1:0] KIND_DROP  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;

  localparam logic [1:0] NB_UP    = 2'd0;
  localparam logic [1:0] NB_DOWN  = 2'd1;
  localparam logic [1:0] NB_LEFT  = 2'd2;
  localparam logic [1:0] NB_RIGHT = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_APPLY,
    ST_POP,
    ST_CADDR,
    ST_CAPPLY,
    ST_NSEL,
    ST_NAPPLY,
    ST_CPUSH,
    ST_FLOAD,
    ST_FAPPLY,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

@@ rtl/sgd_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none
module sgd_ram #(
  parameter int W = 8,
  parameter int A = 8
) (
  input  wire logic         clk,
  input  wire logic         we,
  input  wire logic [A-1:0] waddr,
  input  wire logic [W-1:0] wdata,
  input  wire logic [A-1:0] raddr,
  output logic      [W-1:0] rdata
);

  logic [W-1:0] mem [(1<<A)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/sgd_seq.sv @@
// Sequencer: item handling, topple work list walk and result register.
`default_nettype none
`include "sandpile_grain_drop_defines.svh"
module sgd_seq
  import sgd_pkg::*;
#(
  parameter int GRID_SIDE = DEFAULT_GRID_SIDE,
  parameter int CW        = $clog2(GRID_SIDE),
  parameter int AW        = 2 * CW,
  parameter int HW        = $clog2(3 * GRID_SIDE * GRID_SIDE + 2)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  input  wire logic [IN_TUSER_W-1:0]  s_tuser,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic      [OUT_TDATA_W-1:0] m_tdata,
  output logic                        h_we,
  output logic      [AW-1:0]          h_waddr,
  output logic      [HW-1:0]          h_wdata,
  output logic      [AW-1:0]          h_raddr,
  input  wire logic [HW-1:0]          h_rdata,
  output logic                        p_we,
  output logic      [AW-1:0]          p_waddr,
  output logic      [AW-1:0]          p_wdata,
  output logic      [AW-1:0]          p_raddr,
  input  wire logic [AW-1:0]          p_rdata
);

  state_t              state, state_next;
  logic [1:0]          kind, kind_next;
  logic [CW-1:0]       irow, irow_next, icol, icol_next;
  logic [1:0]          ih, ih_next;
  logic                in_grid, in_grid_next;
  logic [AW:0]         pcnt, pcnt_next;
  logic [AW-1:0]       center, center_next;
  logic [HW-1:0]       center_h, center_h_next;
  logic [1:0]          nb, nb_next;
  logic [TOPPLE_W-1:0] topples, topples_next;
  logic [AW-1:0]       clr, clr_next;
  logic [SIZE_W-1:0]   size, size_next;
  logic                sat, sat_next;
  logic [1:0]          res_h, res_h_next;

  logic [AW-1:0] item_idx;
  logic [CW-1:0] cr, cc;
  logic          nb_ok;
  logic [AW-1:0] nb_addr;
  logic [HW-1:0] h_inc;
  logic [3:0]    in_row, in_col;

  assign item_idx = {irow, icol};
  assign cr       = center[AW-1:CW];
  assign cc       = center[CW-1:0];
  assign h_inc    = h_rdata + HW'(1);
  assign in_row   = s_tdata[3:0];
  assign in_col   = s_tdata[7:4];
  assign m_tdata  = {5'b0, res_h, sat, size};

  always_comb begin
    unique case (nb)
      NB_UP: begin
        nb_ok   = cr != '0;
        nb_addr = {cr - CW'(1), cc};
      end
      NB_DOWN: begin
        nb_ok   = (32'(cr) + 32'd1) < 32'(GRID_SIDE);
        nb_addr = {cr + CW'(1), cc};
      end
      NB_LEFT: begin
        nb_ok   = cc != '0;
        nb_addr = {cr, cc - CW'(1)};
      end
      default: begin
        nb_ok   = (32'(cc) + 32'd1) < 32'(GRID_SIDE);
        nb_addr = {cr, cc + CW'(1)};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      pcnt    <= '0;
      clr     <= '0;
    end else begin
      state   <= state_next;
      pcnt    <= pcnt_next;
      clr     <= clr_next;
    end
    kind     <= kind_next;
    irow     <= irow_next;
    icol     <= icol_next;
    ih       <= ih_next;
    in_grid  <= in_grid_next;
    center   <= center_next;
    center_h <= center_h_next;
    nb       <= nb_next;
    topples  <= topples_next;
    size     <= size_next;
    sat      <= sat_next;
    res_h    <= res_h_next;
  end

  always_comb begin
    state_next    = state;
    kind_next     = kind;
    irow_next     = irow;
    icol_next     = icol;
    ih_next       = ih;
    in_grid_next  = in_grid;
    pcnt_next     = pcnt;
    center_next   = center;
    center_h_next = center_h;
    nb_next       = nb;
    topples_next  = topples;
    clr_next      = clr;
    size_next     = size;
    sat_next      = sat;
    res_h_next    = res_h;
    s_tready      = 1'b0;
    m_tvalid      = 1'b0;
    h_we          = 1'b0;
    h_waddr       = item_idx;
    h_wdata       = '0;
    h_raddr       = item_idx;
    p_we          = 1'b0;
    p_waddr       = pcnt[AW-1:0];
    p_wdata       = item_idx;
    p_raddr       = pcnt[AW-1:0] - AW'(1);

    unique case (state)
      ST_CLEAR: begin
        h_we     = 1'b1;
        h_waddr  = clr;
        clr_next = clr + AW'(1);
        if (clr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          kind_next    = s_tuser;
          irow_next    = CW'(in_row);
          icol_next    = CW'(in_col);
          ih_next      = s_tdata[9:8];
          in_grid_next = (32'(in_row) < 32'(GRID_SIDE)) && (32'(in_col) < 32'(GRID_SIDE));
          state_next   = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next = ST_APPLY;
      end
      ST_APPLY: begin
        size_next    = '0;
        sat_next     = 1'b0;
        topples_next = '0;
        state_next   = ST_OUT;
        if (!in_grid) begin
          res_h_next = '0;
        end else begin
          unique case (kind)
            KIND_DROP: begin
              h_we       = 1'b1;
              h_wdata    = h_inc;
              res_h_next = h_inc[1:0];
              if (h_inc == HW'(TOPPLE_AT)) begin
                p_we       = 1'b1;
                p_waddr    = '0;
                pcnt_next  = (AW+1)'(1);
                state_next = ST_POP;
              end
            end
            KIND_WRITE: begin
              h_we       = 1'b1;
              h_wdata    = HW'(ih);
              res_h_next = ih;
            end
            default: begin
              res_h_next = h_rdata[1:0];
            end
          endcase
        end
      end
      ST_POP: begin
        if (pcnt == '0) begin
          state_next = ST_FLOAD;
        end else begin
          pcnt_next  = pcnt - (AW+1)'(1);
          state_next = ST_CADDR;
        end
      end
      ST_CADDR: begin
        center_next = p_rdata;
        h_raddr     = p_rdata;
        state_next  = ST_CAPPLY;
      end
      ST_CAPPLY: begin
        state_next = ST_POP;
        if (h_rdata >= HW'(TOPPLE_AT)) begin
          h_we          = 1'b1;
          h_waddr       = center;
          h_wdata       = h_rdata - HW'(TOPPLE_AT);
          center_h_next = h_rdata - HW'(TOPPLE_AT);
          if (!topples[TOPPLE_W-1]) begin
            topples_next = topples + TOPPLE_W'(1);
          end
          nb_next    = NB_UP;
          state_next = ST_NSEL;
        end
      end
      ST_NSEL: begin
        h_raddr = nb_addr;
        if (nb_ok) begin
          state_next = ST_NAPPLY;
        end else if (nb == NB_RIGHT) begin
          state_next = ST_CPUSH;
        end else begin
          nb_next = nb + 2'd1;
        end
      end
      ST_NAPPLY: begin
        h_we    = 1'b1;
        h_waddr = nb_addr;
        h_wdata = h_inc;
        if (h_inc == HW'(TOPPLE_AT)) begin
          p_we      = 1'b1;
          p_wdata   = nb_addr;
          pcnt_next = pcnt + (AW+1)'(1);
        end
        if (nb == NB_RIGHT) begin
          state_next = ST_CPUSH;
        end else begin
          nb_next    = nb + 2'd1;
          state_next = ST_NSEL;
        end
      end
      ST_CPUSH: begin
        if (center_h >= HW'(TOPPLE_AT)) begin
          p_we      = 1'b1;
          p_wdata   = center;
          pcnt_next = pcnt + (AW+1)'(1);
        end
        state_next = ST_POP;
      end
      ST_FLOAD: begin
        state_next = ST_FAPPLY;
      end
      ST_FAPPLY: begin
        res_h_next = h_rdata[1:0];
        sat_next   = topples[TOPPLE_W-1];
        size_next  = topples[TOPPLE_W-1] ? '1 : {topples[TOPPLE_W-2:0], 2'b00};
        state_next = ST_OUT;
      end
      ST_OUT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `SGD_ASSERT_ALWAYS(a_pcnt_bound, 32'(pcnt) <= (32'd1 << AW), "work list overflow")
  `SGD_ASSERT_IMP(a_center_full, state == ST_CAPPLY, h_rdata >= HW'(TOPPLE_AT), "stable pop")
  `SGD_ASSERT_IMP(a_out_drained, m_tvalid, pcnt == '0, "result with pending cells")
  `SGD_ASSERT_NEXT(a_accept_load, s_tvalid && s_tready, state == ST_LOAD, "accept lost")

endmodule
`default_nettype wire

@@ rtl/sandpile_grain_drop.sv @@
// Top level of the sandpile grain drop block.
//
//  channel | dir | tdata (low bit up)                        | tuser
//  s_      | in  | row[3:0] col[7:4] height[9:8] zero pad    | kind[1:0]
//  m_      | out | avalanche_size[31:0] saturated[32]        | -
//          |     | cell_height[34:33] zero pad               |
//
// Write, read and calm drop: the item passes ST_LOAD and ST_APPLY from accept to result valid in ST_OUT.
// Each topple walks ST_POP, ST_CADDR and ST_CAPPLY, then ST_NSEL and ST_NAPPLY per in-grid neighbor
// or ST_NSEL alone per grid edge, then ST_CPUSH; ST_POP, ST_FLOAD and ST_FAPPLY end the walk.
// After reset a clearing pass writes zeros to all 2^(2*clog2(GRID_SIDE)) height RAM entries.
// One transaction in flight; s_tready stays low until the result is taken.
`default_nettype none
module sandpile_grain_drop
  import sgd_pkg::*;
#(
  parameter int GRID_SIDE = DEFAULT_GRID_SIDE
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // row, col, height
  input  wire logic [IN_TUSER_W-1:0]  s_tuser,   // kind
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic      [OUT_TDATA_W-1:0] m_tdata    // avalanche_size, saturated, cell_height
);

  localparam int CW = $clog2(GRID_SIDE);
  localparam int AW = 2 * CW;
  localparam int HW = $clog2(3 * GRID_SIDE * GRID_SIDE + 2);

  logic          h_we, p_we;
  logic [AW-1:0] h_waddr, h_raddr, p_waddr, p_wdata, p_raddr, p_rdata;
  logic [HW-1:0] h_wdata, h_rdata;

  sgd_ram #(.W(HW), .A(AW)) u_height (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  sgd_ram #(.W(AW), .A(AW)) u_pending (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  sgd_seq #(.GRID_SIDE(GRID_SIDE), .CW(CW), .AW(AW), .HW(HW)) u_seq (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .h_we     (h_we),
    .h_waddr  (h_waddr),
    .h_wdata  (h_wdata),
    .h_raddr  (h_raddr),
    .h_rdata  (h_rdata),
    .p_we     (p_we),
    .p_waddr  (p_waddr),
    .p_wdata  (p_wdata),
    .p_raddr  (p_raddr),
    .p_rdata  (p_rdata)
  );

endmodule
`default_nettype wire
